@@ rtl/mips_prologue_frame_decoder_assert.svh @@
// Assertion macros used by the checker file of the prologue frame decoder.
`ifndef MIPS_PROLOGUE_FRAME_DECODER_ASSERT_SVH
`define MIPS_PROLOGUE_FRAME_DECODER_ASSERT_SVH

// Same-cycle implication, skipped while reset is high.
`define MPFD_ASSERT_IMPLY(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("mpfd assertion failed");

// Next-cycle implication, skipped while reset is high.
`define MPFD_ASSERT_NEXT(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("mpfd assertion failed");

`endif

@@ rtl/mpfd_pkg.sv @@
// Types, opcode constants and widths of the prologue frame decoder.
package mpfd_pkg;

  localparam int FRAME_W  = 22;
  localparam int RA_W     = 21;
  localparam int BITE_W   = 16;
  localparam int OFFS_W   = 15;
  localparam int BITE_MAX = 32768;

  localparam logic [FRAME_W-1:0] FRAME_MAX = '1;
  localparam logic [RA_W-1:0]    RA_MAX    = '1;

  localparam logic [31:0] ITYPE_MASK  = 32'hffff0000;
  localparam logic [31:0] ADDIU_SP_SP = 32'h27bd0000;
  localparam logic [31:0] SD_RA_SP    = 32'hffbf0000;
  localparam logic [31:0] SW_RA_SP    = 32'hafbf0000;
  localparam logic [31:0] SPREG_MASK  = 32'hffe0ffc0;
  localparam logic [31:0] SPREG_OP    = 32'h03a0e800;

  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_REGIMM  = 6'h01;
  localparam logic [5:0] OP_BGTZ    = 6'h07;
  localparam logic [5:0] OP_BEQL    = 6'h14;
  localparam logic [5:0] OP_BGTZL   = 6'h17;

  localparam logic [5:0] FN_JR    = 6'h08;
  localparam logic [5:0] FN_JALR  = 6'h09;
  localparam logic [5:0] FN_ADDU  = 6'h21;
  localparam logic [5:0] FN_SUBU  = 6'h23;
  localparam logic [5:0] FN_DADDU = 6'h2d;
  localparam logic [5:0] FN_DSUBU = 6'h2f;

  typedef enum logic [1:0] {
    VERDICT_NONE    = 2'd0,
    VERDICT_UNDEC   = 2'd1,
    VERDICT_DECODED = 2'd2
  } verdict_t;

  // Classification of one instruction word.
  typedef struct packed {
    logic              is_branch;
    logic              is_reg_adj;
    logic              is_addiu;
    logic              is_ra_store;
    logic              neg_imm;
    logic [BITE_W-1:0] bite;
    logic [OFFS_W-1:0] offset;
  } word_class_t;

  // Control of the word that leaves the input register this cycle.
  typedef struct packed {
    logic fire;
    logic start;
    logic text_end;
  } step_t;

  typedef struct packed {
    verdict_t           verdict;
    logic [FRAME_W-1:0] frame_size;
    logic [RA_W-1:0]    ra_offset;
  } result_t;

endpackage

@@ rtl/mips_prologue_frame_decoder.sv @@
// Top level of the MIPS prologue frame decoder: input register and scan stage.
//
//   channel  direction  handshake            payload
//   in       sink       in_valid / in_stall   word, start_req, text_end
//   out      source     out_valid / out_stall verdict, frame_size, ra_offset
//
// One word per cycle while in_stall is low: a word is held in the input register, is
// judged by the scan stage, and any verdict it gives is registered at the output.
// An empty input register can still take a word while a verdict waits at the output.
// Only a full input register behind a stalled verdict stalls the input.
// Reset is synchronous and leaves the block idle with no verdict pending.
module mips_prologue_frame_decoder #(
  parameter int BODY_LIMIT = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [31:0]                   word,
  input  logic                          start_req,
  input  logic                          text_end,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    verdict,
  output logic [mpfd_pkg::FRAME_W-1:0]  frame_size,
  output logic [mpfd_pkg::RA_W-1:0]     ra_offset
);
  import mpfd_pkg::*;

  logic        s1_valid;
  logic [31:0] s1_word;
  logic        s1_start;
  logic        s1_text_end;
  logic        advance;
  logic        accept;

  step_t       step;
  word_class_t cls;

  // The scan stage may move only when the result register can take a word.
  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !advance;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_word     <= word;
      s1_start    <= start_req;
      s1_text_end <= text_end;
    end
  end

  assign step.fire     = s1_valid && advance;
  assign step.start    = s1_start;
  assign step.text_end = s1_text_end;

  mpfd_decode u_decode (
    .word (s1_word),
    .cls  (cls)
  );

  mpfd_scan #(
    .BODY_LIMIT (BODY_LIMIT)
  ) u_scan (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .cls        (cls),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .verdict    (verdict),
    .frame_size (frame_size),
    .ra_offset  (ra_offset)
  );

endmodule

@@ rtl/mpfd_decode.sv @@
// Instruction word classifier: branches, sp adjustments and return-address stores.
module mpfd_decode (
  input  logic [31:0]          word,
  output mpfd_pkg::word_class_t cls
);
  import mpfd_pkg::*;

  logic [5:0]  op;
  logic [5:0]  funct;
  logic [15:0] imm;

  assign op    = word[31:26];
  assign funct = word[5:0];
  assign imm   = word[15:0];

  always_comb begin
    if (op == OP_SPECIAL) begin
      cls.is_branch = (funct == FN_JR) || (funct == FN_JALR);
    end else begin
      cls.is_branch = ((op >= OP_REGIMM) && (op <= OP_BGTZ)) ||
                      ((op >= OP_BEQL) && (op <= OP_BGTZL));
    end
    cls.is_reg_adj  = ((word & SPREG_MASK) == SPREG_OP) &&
                      ((funct == FN_ADDU) || (funct == FN_SUBU) ||
                       (funct == FN_DADDU) || (funct == FN_DSUBU));
    cls.is_addiu    = (word & ITYPE_MASK) == ADDIU_SP_SP;
    cls.is_ra_store = ((word & ITYPE_MASK) == SD_RA_SP) ||
                      ((word & ITYPE_MASK) == SW_RA_SP);
    cls.neg_imm     = imm[15];
    // Magnitude of a negative immediate; 16'h8000 stands for 32768.
    cls.bite        = ~imm + 16'd1;
    cls.offset      = imm[OFFS_W-1:0];
  end

endmodule

@@ rtl/mpfd_scan.sv @@
// Scan state, frame and spill accumulation, and the verdict register.
module mpfd_scan #(
  parameter int BODY_LIMIT = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  mpfd_pkg::step_t               step,
  input  mpfd_pkg::word_class_t         cls,
  input  logic                          out_stall,
  output logic                          out_valid,
  output logic [1:0]                    verdict,
  output logic [mpfd_pkg::FRAME_W-1:0]  frame_size,
  output logic [mpfd_pkg::RA_W-1:0]     ra_offset
);
  import mpfd_pkg::*;

  localparam int POS_W   = $clog2(BODY_LIMIT + 1);
  localparam int SUM_RAW = $clog2((BODY_LIMIT + 2) * BITE_MAX + 1);
  localparam int SUM_W   = (SUM_RAW > FRAME_W + 1) ? SUM_RAW : FRAME_W + 1;

  logic             scanning, scanning_next;
  logic             in_delay_slot, in_delay_slot_next;
  logic [POS_W-1:0] body_position, body_position_next;
  logic [SUM_W-1:0] frame_total, frame_total_next;
  logic             spill_found, spill_found_next;
  logic [SUM_W-1:0] spill_offset, spill_offset_next;

  logic             emit;
  result_t          res;

  logic [SUM_W-1:0] p_frame, p_spill;
  logic             p_found;
  logic [POS_W-1:0] pos_inc;
  logic             stop;

  function automatic result_t judge(input logic [SUM_W-1:0] ft, input logic found,
                                    input logic [SUM_W-1:0] sp);
    result_t r;
    r.verdict    = VERDICT_NONE;
    r.frame_size = '0;
    r.ra_offset  = '0;
    if (found && (sp < ft)) begin
      r.verdict    = VERDICT_DECODED;
      r.frame_size = (ft > SUM_W'(FRAME_MAX)) ? FRAME_MAX : ft[FRAME_W-1:0];
      r.ra_offset  = (sp > SUM_W'(RA_MAX)) ? RA_MAX : sp[RA_W-1:0];
    end
    return r;
  endfunction

  // Effect of the current word on the frame and the spill offset.
  always_comb begin
    p_frame = frame_total;
    p_spill = spill_offset;
    p_found = spill_found;
    if (cls.is_addiu && cls.neg_imm) begin
      p_frame = frame_total + SUM_W'(cls.bite);
      if (spill_found) begin
        p_spill = spill_offset + SUM_W'(cls.bite);
      end
    end else if (cls.is_ra_store && !spill_found && !cls.neg_imm) begin
      p_found = 1'b1;
      p_spill = SUM_W'(cls.offset);
    end
    stop    = cls.is_addiu && !cls.neg_imm;
    pos_inc = body_position + POS_W'(1);
  end

  always_comb begin
    scanning_next      = scanning;
    in_delay_slot_next = in_delay_slot;
    body_position_next = body_position;
    frame_total_next   = frame_total;
    spill_found_next   = spill_found;
    spill_offset_next  = spill_offset;
    emit               = 1'b0;
    res                = judge(frame_total, spill_found, spill_offset);
    if (step.fire) begin
      priority if (step.start) begin
        in_delay_slot_next = 1'b0;
        spill_found_next   = 1'b0;
        spill_offset_next  = '0;
        if (step.text_end || !cls.neg_imm) begin
          // Nothing opens a frame here.
          scanning_next      = 1'b0;
          body_position_next = '0;
          frame_total_next   = '0;
          emit               = 1'b1;
          res                = judge('0, 1'b0, '0);
        end else begin
          scanning_next      = 1'b1;
          body_position_next = POS_W'(1);
          frame_total_next   = SUM_W'(cls.bite);
        end
      end else if (!scanning) begin
        // Words outside a scan are dropped.
      end else if (step.text_end) begin
        emit = 1'b1;
      end else if (in_delay_slot) begin
        emit = 1'b1;
        if (cls.is_reg_adj) begin
          res.verdict    = VERDICT_UNDEC;
          res.frame_size = '0;
          res.ra_offset  = '0;
        end else begin
          res = judge(p_frame, p_found, p_spill);
        end
      end else if (cls.is_branch) begin
        in_delay_slot_next = 1'b1;
      end else if (cls.is_reg_adj) begin
        emit           = 1'b1;
        res.verdict    = VERDICT_UNDEC;
        res.frame_size = '0;
        res.ra_offset  = '0;
      end else if (stop) begin
        emit = 1'b1;
      end else begin
        body_position_next = pos_inc;
        frame_total_next   = p_frame;
        spill_found_next   = p_found;
        spill_offset_next  = p_spill;
        if (pos_inc >= POS_W'(BODY_LIMIT)) begin
          emit = 1'b1;
          res  = judge(p_frame, p_found, p_spill);
        end
      end
      if (emit) begin
        scanning_next      = 1'b0;
        in_delay_slot_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scanning      <= 1'b0;
      in_delay_slot <= 1'b0;
      body_position <= '0;
      frame_total   <= '0;
      spill_found   <= 1'b0;
      spill_offset  <= '0;
      out_valid     <= 1'b0;
    end else begin
      scanning      <= scanning_next;
      in_delay_slot <= in_delay_slot_next;
      body_position <= body_position_next;
      frame_total   <= frame_total_next;
      spill_found   <= spill_found_next;
      spill_offset  <= spill_offset_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      verdict    <= res.verdict;
      frame_size <= res.frame_size;
      ra_offset  <= res.ra_offset;
    end
  end

endmodule

@@ rtl/mpfd_checker.sv @@
// Port-level checks of the prologue frame decoder and their bind.
`include "mips_prologue_frame_decoder_assert.svh"

module mpfd_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [1:0]                    verdict,
  input logic [mpfd_pkg::FRAME_W-1:0]  frame_size,
  input logic [mpfd_pkg::RA_W-1:0]     ra_offset
);
  import mpfd_pkg::*;

  // A stalled verdict word stays offered.
  `MPFD_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid)

  // Only decoded verdicts carry a frame.
  `MPFD_ASSERT_IMPLY(a_plain_zero, clk, rst, out_valid && (verdict != VERDICT_DECODED),
                     (frame_size == '0) && (ra_offset == '0))

  // A decoded spill always lies inside the frame, also when saturated.
  `MPFD_ASSERT_IMPLY(a_spill_inside, clk, rst, out_valid && (verdict == VERDICT_DECODED),
                     ra_offset < frame_size)

  `MPFD_ASSERT_IMPLY(a_verdict_code, clk, rst, out_valid,
                     (verdict == VERDICT_NONE) || (verdict == VERDICT_UNDEC) ||
                     (verdict == VERDICT_DECODED))

endmodule

bind mips_prologue_frame_decoder mpfd_checker u_mpfd_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .verdict    (verdict),
  .frame_size (frame_size),
  .ra_offset  (ra_offset)
);
